// File: sv/srr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// srr_pkg: shared types and constants of the selective-repeat receiver
// Packet and result beat layouts, ring geometry and the sequencer state
// codes.
// ----------------------------------------------------------------------------
package srr_pkg;

    // The ring is indexed by the low sequence bits, so its depth is a power of two.
    localparam int RING_DEPTH    = 32;
    localparam int RING_AW       = $clog2(RING_DEPTH);
    localparam int PAYLOAD_BYTES = 20;
    localparam int PAYLOAD_W     = PAYLOAD_BYTES * 8;
    localparam int BYTE_CNT_W    = $clog2(PAYLOAD_BYTES);
    localparam int CFG_W         = 6;
    localparam int SEQ_W         = 31;

    localparam logic [CFG_W-1:0] WIN_RESET = CFG_W'(8);
    localparam logic [CFG_W-1:0] WIN_MAX   = CFG_W'(RING_DEPTH);
    localparam logic [SEQ_W-1:0] EXP_MAX   = '1;

    localparam logic KIND_ACK  = 1'b0;
    localparam logic KIND_DATA = 1'b1;

    typedef struct packed {
        logic signed [31:0] seq_num;
        logic signed [31:0] ack_num;
        logic signed [31:0] check_sum;
        logic [63:0]        payload_lo;
        logic [63:0]        payload_mid;
        logic [31:0]        payload_hi;
    } srr_in_t;

    typedef struct packed {
        logic               kind;
        logic [SEQ_W-1:0]   ack_number;
        logic signed [31:0] ack_check;
        logic [63:0]        out_payload_lo;
        logic [63:0]        out_payload_mid;
        logic [31:0]        out_payload_hi;
        logic               last;
    } srr_out_t;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_SUM  = 5'b00010,
        S_ACK  = 5'b00100,
        S_RD   = 5'b01000,
        S_DLV  = 5'b10000
    } srr_state_t;

endpackage
`default_nettype wire

// File: sv/srr_csum.sv
`default_nettype none
// ----------------------------------------------------------------------------
// srr_csum: iterative packet checksum unit
// Seeds the accumulator with sequence plus ack number, then adds one
// sign-extended payload byte per cycle into a 32-bit accumulator.
// ----------------------------------------------------------------------------
module srr_csum
    import srr_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire logic [31:0]          seq_num,
    input  wire logic [31:0]          ack_num,
    input  wire logic [PAYLOAD_W-1:0] payload,
    output logic                      done,
    output logic [31:0]               sum
);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [BYTE_CNT_W-1:0] cnt_reg, cnt_next;
    logic [PAYLOAD_W-1:0]  shift_reg, shift_next;
    logic [31:0]           acc_reg, acc_next;
    logic [7:0]            cur_byte;

    assign cur_byte = shift_reg[7:0];

    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        cnt_next   = cnt_reg;
        shift_next = shift_reg;
        acc_next   = acc_reg;
        if (start)
        begin
            busy_next  = 1'b1;
            cnt_next   = '0;
            shift_next = payload;
            acc_next   = seq_num + ack_num;
        end
        else if (busy_reg)
        begin
            acc_next   = acc_reg + {{24{cur_byte[7]}}, cur_byte};
            shift_next = shift_reg >> 8;
            cnt_next   = cnt_reg + 1'b1;
            if (cnt_reg == BYTE_CNT_W'(PAYLOAD_BYTES - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        acc_reg   <= acc_next;
    end

    assign done = done_reg;
    assign sum  = acc_reg;

endmodule
`default_nettype wire

// File: sv/selective_repeat_receiver.sv
`default_nettype none
// ----------------------------------------------------------------------------
// selective_repeat_receiver: selective-repeat ARQ receive side
// Checks each packet, acks it, holds out-of-order packets in a reorder ring
// and delivers the in-order run upward.
// ----------------------------------------------------------------------------
// Usage.
// Packets enter on in_valid/in_ready/in_data, one beat per packet. Results
// leave on out_valid/out_ready/out_data: an ack beat (kind 0) first, then any
// delivery beats (kind 1) in sequence order; last marks the final beat of a
// packet. A corrupt, negative or out-of-window packet gives no beat.
// The window width is written on cfg_valid/cfg_data, which is always ready,
// and is limited to the ring depth in use.
// The checksum unit adds one payload byte per cycle, so the ack beat can only
// be loaded once the whole payload has been summed. Each delivery then takes
// a ring read (S_RD) and a load of the output register (S_DLV). in_ready is
// low from the time a packet is taken until its last beat is loaded, or until
// it is dropped. While out_ready holds a beat back the block waits and loses
// nothing. Reset clears the ring's valid bits, the expected sequence number
// and the window (back to 8) at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module selective_repeat_receiver
    import srr_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire srr_in_t          in_data,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output srr_out_t              out_data,
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic [CFG_W-1:0] cfg_data
);

    srr_state_t            state_reg, state_next;
    srr_in_t               in_reg;
    logic [SEQ_W-1:0]      exp_reg, exp_next;
    logic [CFG_W-1:0]      win_reg;
    logic [RING_DEPTH-1:0] slot_valid_reg, slot_valid_next;
    logic                  drain_reg, drain_next;
    logic                  ack_last_reg, ack_last_next;
    logic                  out_valid_reg, out_valid_next;
    srr_out_t              out_data_reg, out_data_next;
    logic [PAYLOAD_W-1:0]  rd_reg;
    logic [PAYLOAD_W-1:0]  ring_mem [RING_DEPTH];

    logic                  accept;
    logic                  out_free;
    logic                  out_load;
    logic                  mem_we;
    logic                  rd_en;
    logic                  csum_done;
    logic [31:0]           csum_sum;
    logic [PAYLOAD_W-1:0]  in_payload;
    logic [SEQ_W-1:0]      seq31;
    logic [RING_AW-1:0]    idx_seq, idx_exp, idx_nxt;
    logic [CFG_W-1:0]      win_lim;
    logic [SEQ_W:0]        win_end;
    logic [SEQ_W-1:0]      exp_sat;
    logic                  more;

    assign accept     = in_valid && in_ready;
    assign in_ready   = (state_reg == S_IDLE);
    assign cfg_ready  = 1'b1;
    assign out_free   = !out_valid_reg || out_ready;
    assign in_payload = {in_data.payload_hi, in_data.payload_mid, in_data.payload_lo};

    srr_csum u_csum (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (accept),
        .seq_num (in_data.seq_num),
        .ack_num (in_data.ack_num),
        .payload (in_payload),
        .done    (csum_done),
        .sum     (csum_sum)
    );

    assign seq31   = in_reg.seq_num[SEQ_W-1:0];
    assign idx_seq = seq31[RING_AW-1:0];
    assign idx_exp = exp_reg[RING_AW-1:0];
    assign win_lim = (win_reg > WIN_MAX) ? WIN_MAX : win_reg;
    assign win_end = {1'b0, exp_reg} + (SEQ_W + 1)'(win_lim);
    // At saturation the expected number stays put, and its slot is being freed.
    assign exp_sat = (exp_reg == EXP_MAX) ? exp_reg : exp_reg + 1'b1;
    assign idx_nxt = exp_sat[RING_AW-1:0];
    assign more    = (exp_sat != exp_reg) && slot_valid_reg[idx_nxt];

    always_comb
    begin
        state_next      = state_reg;
        exp_next        = exp_reg;
        slot_valid_next = slot_valid_reg;
        drain_next      = drain_reg;
        ack_last_next   = ack_last_reg;
        out_load        = 1'b0;
        out_data_next   = '0;
        mem_we          = 1'b0;
        rd_en           = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_SUM;
                end
            end
            S_SUM:
            begin
                if (csum_done)
                begin
                    state_next = S_IDLE;
                    if ((csum_sum == $unsigned(in_reg.check_sum)) && !in_reg.seq_num[31])
                    begin
                        if (seq31 < exp_reg)
                        begin
                            ack_last_next = 1'b1;
                            drain_next    = 1'b0;
                            state_next    = S_ACK;
                        end
                        else if ({1'b0, seq31} < win_end)
                        begin
                            mem_we                   = 1'b1;
                            slot_valid_next[idx_seq] = 1'b1;
                            // The expected packet always has at least itself to deliver.
                            ack_last_next            = (seq31 != exp_reg);
                            drain_next               = (seq31 == exp_reg);
                            state_next               = S_ACK;
                        end
                    end
                end
            end
            S_ACK:
            begin
                if (out_free)
                begin
                    out_load                 = 1'b1;
                    out_data_next.kind       = KIND_ACK;
                    out_data_next.ack_number = seq31;
                    out_data_next.ack_check  = {seq31, 1'b0};
                    out_data_next.last       = ack_last_reg;
                    state_next               = drain_reg ? S_RD : S_IDLE;
                end
            end
            S_RD:
            begin
                rd_en      = 1'b1;
                state_next = S_DLV;
            end
            S_DLV:
            begin
                if (out_free)
                begin
                    out_load                      = 1'b1;
                    out_data_next.kind            = KIND_DATA;
                    out_data_next.out_payload_lo  = rd_reg[63:0];
                    out_data_next.out_payload_mid = rd_reg[127:64];
                    out_data_next.out_payload_hi  = rd_reg[159:128];
                    out_data_next.last            = !more;
                    slot_valid_next[idx_exp]      = 1'b0;
                    exp_next                      = exp_sat;
                    state_next                    = more ? S_RD : S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            exp_reg        <= '0;
            win_reg        <= WIN_RESET;
            slot_valid_reg <= '0;
            drain_reg      <= 1'b0;
            ack_last_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            exp_reg        <= exp_next;
            slot_valid_reg <= slot_valid_next;
            drain_reg      <= drain_next;
            ack_last_reg   <= ack_last_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                win_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_reg <= in_data;
        end
        if (out_load)
        begin
            out_data_reg <= out_data_next;
        end
    end

    // Reorder ring: one write port for storing, one registered read for draining.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            ring_mem[idx_seq] <= {in_reg.payload_hi, in_reg.payload_mid, in_reg.payload_lo};
        end
        if (rd_en)
        begin
            rd_reg <= ring_mem[idx_exp];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // The expected sequence number only ever moves forward.
    a_exp_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        $past(exp_reg) <= exp_reg)
        else $error("expected sequence number went backwards");

    // A ring read is only issued for a slot that holds a packet.
    a_read_valid_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RD) |-> slot_valid_reg[idx_exp])
        else $error("ring read of an empty slot");

    // A delivery beat always frees its slot and advances or holds the count.
    a_dlv_frees_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DLV && out_free) |=> !slot_valid_reg[$past(idx_exp)])
        else $error("delivered slot still marked valid");

    // No packet is taken while the previous one is being worked on.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !in_ready)
        else $error("second packet accepted during processing");

endmodule
`default_nettype wire

// File: verif/srr_delivery_monitor.sv
// ----------------------------------------------------------------------------
// srr_delivery_monitor: reorder-ring predictor and result comparator
// Watches the packet, result and window channels of the selective-repeat
// receiver, predicts the ack and delivery beats of every packet taken, and
// compares each result beat field by field with the oldest one predicted.
// ----------------------------------------------------------------------------
module srr_delivery_monitor
    import srr_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    input  wire logic             in_ready,
    input  wire srr_in_t          in_data,
    input  wire logic             out_valid,
    input  wire logic             out_ready,
    input  wire srr_out_t         out_data,
    input  wire logic             cfg_valid,
    input  wire logic             cfg_ready,
    input  wire logic [CFG_W-1:0] cfg_data,
    output int                    mismatches,
    output int                    pending
);

    logic [CFG_W-1:0] rx_window;
    logic [SEQ_W-1:0] next_expected;
    logic             held       [RING_DEPTH];
    logic [63:0]      held_lo    [RING_DEPTH];
    logic [63:0]      held_mid   [RING_DEPTH];
    logic [31:0]      held_hi    [RING_DEPTH];
    srr_out_t         due_beats  [$];
    int               err_count = 0;

    // Sum of the twenty payload bytes, each sign-extended, plus both numbers.
    function automatic logic [31:0] packet_sum(input srr_in_t p);
        logic [PAYLOAD_W-1:0] bytes;
        logic [31:0]          total;
        int                   i;
        bytes = {p.payload_hi, p.payload_mid, p.payload_lo};
        total = p.seq_num + p.ack_num;
        for (i = 0; i < PAYLOAD_BYTES; i++)
            total = total + {{24{bytes[8*i+7]}}, bytes[8*i +: 8]};
        return total;
    endfunction

    task automatic absorb_packet(input srr_in_t p);
        longint             seq;
        longint             win;
        int                 guard;
        logic [RING_AW-1:0] idx;
        srr_out_t           carry;
        seq = longint'(p.seq_num);
        if (packet_sum(p) != p.check_sum || seq < 0)
            return;
        win = (rx_window > RING_DEPTH) ? RING_DEPTH : longint'(rx_window);

        carry            = '0;
        carry.kind       = KIND_ACK;
        carry.ack_number = p.seq_num[SEQ_W-1:0];
        carry.ack_check  = {p.seq_num[30:0], 1'b0};

        if (seq < longint'(next_expected)) begin
            carry.last = 1'b1;
            due_beats.insert(due_beats.size(), carry);
            return;
        end
        if (seq >= longint'(next_expected) + win)
            return;

        idx           = p.seq_num[RING_AW-1:0];
        held[idx]     = 1'b1;
        held_lo[idx]  = p.payload_lo;
        held_mid[idx] = p.payload_mid;
        held_hi[idx]  = p.payload_hi;

        // The beat in hand is only released once it is known not to be the last.
        if (seq == longint'(next_expected)) begin
            for (guard = 0; guard < RING_DEPTH; guard++) begin
                idx = next_expected[RING_AW-1:0];
                if (!held[idx])
                    break;
                due_beats.insert(due_beats.size(), carry);
                carry                 = '0;
                carry.kind            = KIND_DATA;
                carry.out_payload_lo  = held_lo[idx];
                carry.out_payload_mid = held_mid[idx];
                carry.out_payload_hi  = held_hi[idx];
                held[idx]             = 1'b0;
                if (next_expected != EXP_MAX)
                    next_expected = next_expected + 1'b1;
            end
        end
        carry.last = 1'b1;
        due_beats.insert(due_beats.size(), carry);
    endtask

    function automatic bit field_agrees(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            return 1'b0;
        end
        return 1'b1;
    endfunction

    task automatic compare_beat(input srr_out_t got);
        srr_out_t want;
        bit       ok;
        if (due_beats.size() == 0) begin
            $error("result beat with nothing predicted: kind %0d last %0d",
                   got.kind, got.last);
            err_count++;
            return;
        end
        want = due_beats.pop_front();
        ok = 1'b1;
        ok &= field_agrees("kind", want.kind, got.kind);
        ok &= field_agrees("ack_number", want.ack_number, got.ack_number);
        ok &= field_agrees("ack_check", want.ack_check, got.ack_check);
        ok &= field_agrees("out_payload_lo", want.out_payload_lo, got.out_payload_lo);
        ok &= field_agrees("out_payload_mid", want.out_payload_mid, got.out_payload_mid);
        ok &= field_agrees("out_payload_hi", want.out_payload_hi, got.out_payload_hi);
        ok &= field_agrees("last", want.last, got.last);
        if (!ok)
            err_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_window     = WIN_RESET;
            next_expected = '0;
            for (int i = 0; i < RING_DEPTH; i++)
                held[i] = 1'b0;
            due_beats.delete();
        end
        else
        begin
            if (out_valid && out_ready)
                compare_beat(out_data);
            if (cfg_valid && cfg_ready)
                rx_window = cfg_data;
            if (in_valid && in_ready)
                absorb_packet(in_data);
        end
        pending    <= due_beats.size();
        mismatches <= err_count;
    end

endmodule

// File: verif/selective_repeat_receiver_tb.sv
// ----------------------------------------------------------------------------
// selective_repeat_receiver_tb: stimulus and verdict for the ARQ receiver
// Sends directed packets covering field extremes, corruption, negative, old
// and out-of-window sequence numbers, then bursts of descending or shuffled
// in-window packets with retransmissions and stray packets under several
// window widths, with random idling on both sides.
// ----------------------------------------------------------------------------
module selective_repeat_receiver_tb
    import srr_pkg::*;
();

    localparam int LIMIT         = 400000;
    localparam int SETTLE_CYCLES = 120;
    localparam int TOTAL_ITEMS   = 170;

    logic             clk        = 1'b0;
    logic             rst_n      = 1'b0;
    logic             in_valid   = 1'b0;
    srr_in_t          in_data    = '0;
    logic             in_ready;
    logic             out_valid;
    logic             out_ready  = 1'b0;
    srr_out_t         out_data;
    logic             cfg_valid  = 1'b0;
    logic [CFG_W-1:0] cfg_data   = '0;
    logic             cfg_ready;
    int               mismatches;
    int               pending;

    int               next_seq    = 0;
    int               sent_items  = 0;
    int               cycle_count = 0;
    logic [CFG_W-1:0] window_now  = WIN_RESET;
    bit               steady      = 1'b0;

    selective_repeat_receiver uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    srr_delivery_monitor monitor (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .mismatches (mismatches),
        .pending    (pending)
    );

    always #5 clk = ~clk;

    // The receiving side stalls about one beat in ten, except in steady phases.
    always @(posedge clk)
    begin
        out_ready <= steady || ($urandom_range(0, 99) >= 10);
    end

    initial
    begin
        while (cycle_count < LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("== FAIL ==");
        $finish;
    end

    function automatic srr_in_t build_packet(input logic signed [31:0] seq,
                                             input logic signed [31:0] ack,
                                             input logic [63:0] lo,
                                             input logic [63:0] mid,
                                             input logic [31:0] hi,
                                             input bit spoil);
        srr_in_t              p;
        logic [PAYLOAD_W-1:0] bytes;
        logic [31:0]          total;
        int                   i;
        p.seq_num     = seq;
        p.ack_num     = ack;
        p.payload_lo  = lo;
        p.payload_mid = mid;
        p.payload_hi  = hi;
        bytes = {hi, mid, lo};
        total = seq + ack;
        for (i = 0; i < PAYLOAD_BYTES; i++)
            total = total + {{24{bytes[8*i+7]}}, bytes[8*i +: 8]};
        p.check_sum = spoil ? (total ^ ($urandom | 32'd1)) : total;
        return p;
    endfunction

    function automatic srr_in_t random_packet(input logic signed [31:0] seq,
                                              input bit spoil);
        return build_packet(seq, $urandom, {$urandom, $urandom}, {$urandom, $urandom},
                            $urandom, spoil);
    endfunction

    function automatic int window_in_use();
        return (window_now > RING_DEPTH) ? RING_DEPTH : int'(window_now);
    endfunction

    task automatic send_packet(input srr_in_t p);
        in_data  <= p;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sent_items++;
        if (!steady && $urandom_range(0, 99) < 10)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    endtask

    // Holds the sender off until every predicted beat is out and the block has
    // had time to finish any packet that produces no beat.
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_window(input logic [CFG_W-1:0] width);
        settle();
        cfg_data  <= width;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid  <= 1'b0;
        window_now  = width;
    endtask

    // Packets the receiver must ack only or drop: old, negative, beyond the
    // window even once the current burst has drained, huge, or corrupt.
    task automatic send_stray(input int burst);
        srr_in_t p;
        int      pick;
        pick = $urandom_range(0, 4);
        if (pick == 0 && next_seq == 0)
            pick = 2;
        case (pick)
            0: p = random_packet($urandom_range(0, next_seq - 1), 1'b0);
            1: p = random_packet(32'h8000_0000 | $urandom, 1'b0);
            2: p = random_packet(next_seq + burst + window_in_use() + $urandom_range(0, 3),
                                 1'b0);
            3: p = random_packet(32'h4000_0000 | ($urandom & 32'h7fff_ffff), 1'b0);
            default:
            begin
                p = random_packet($urandom, 1'b0);
                p.check_sum = $urandom;
            end
        endcase
        send_packet(p);
    endtask

    // Sends sequence numbers next_seq .. next_seq+count-1 intact once each, either in
    // descending order or shuffled; when shuffled, corrupted copies are retransmitted.
    task automatic run_burst(input int count, input bit descending);
        int order [$];
        int i;
        int j;
        int tmp;
        int s;
        for (i = 0; i < count; i++)
            order.insert(order.size(), next_seq + i);
        if (descending)
            order.reverse();
        else
            for (i = count - 1; i > 0; i--)
            begin
                j        = $urandom_range(0, i);
                tmp      = order[i];
                order[i] = order[j];
                order[j] = tmp;
            end
        while (order.size() > 0)
        begin
            s = order.pop_front();
            if (!descending && $urandom_range(0, 99) < 8)
            begin
                send_packet(random_packet(s, 1'b1));
                order.insert(order.size(), s);
            end
            else
                send_packet(random_packet(s, 1'b0));
            if (!descending && $urandom_range(0, 99) < 12)
                send_stray(count);
        end
        next_seq += count;
    endtask

    initial
    begin
        int phase;
        int phase_start;
        int burst;
        int s;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, window at its reset width of eight.
        send_packet(build_packet(0, 0, '0, '0, '0, 1'b0));
        send_packet(build_packet(0, -1, '1, '1, '1, 1'b0));
        send_packet(build_packet(2, 32'sh7fff_ffff, 64'h8080_8080_8080_8080,
                                 64'h8080_8080_8080_8080, 32'h8080_8080, 1'b0));
        send_packet(build_packet(1, 32'sh8000_0000, 64'h7f7f_7f7f_7f7f_7f7f,
                                 64'h7f7f_7f7f_7f7f_7f7f, 32'h7f7f_7f7f, 1'b0));
        send_packet(random_packet(3, 1'b1));
        send_packet(random_packet(-1, 1'b0));
        send_packet(random_packet(32'sh8000_0000, 1'b0));
        send_packet(random_packet(32'sh7fff_ffff, 1'b0));
        send_packet(random_packet(11, 1'b0));
        send_packet(random_packet(10, 1'b0));
        send_packet(random_packet(3, 1'b0));
        for (s = 9; s >= 4; s--)
            send_packet(random_packet(s, 1'b0));
        next_seq = 11;

        // A zero window stores nothing but still acks old packets.
        set_window('0);
        send_packet(random_packet(11, 1'b0));
        send_packet(random_packet(5, 1'b0));
        set_window(CFG_W'(1));
        send_packet(random_packet(12, 1'b0));
        send_packet(random_packet(11, 1'b0));
        next_seq = 12;

        phase = 0;
        while (sent_items < TOTAL_ITEMS)
        begin
            case (phase % 8)
                0: set_window('1);
                1: set_window(WIN_MAX);
                2: set_window(CFG_W'(1));
                3: set_window(CFG_W'($urandom_range(2, 31)));
                4: set_window('0);
                5: set_window(WIN_RESET);
                6: set_window(CFG_W'($urandom_range(33, 62)));
                default: set_window(CFG_W'($urandom_range(1, 32)));
            endcase
            steady <= (phase % 8 == 1);
            phase_start = sent_items;
            if (window_in_use() == 0)
                repeat (6)
                begin
                    if ($urandom_range(0, 1) == 1)
                        send_stray(0);
                    else
                        send_packet(random_packet(next_seq + $urandom_range(0, 3), 1'b0));
                end
            else
            begin
                // A full ring released by its lowest packet gives the longest run of beats.
                if (phase == 0)
                    run_burst(RING_DEPTH, 1'b1);
                while (sent_items - phase_start < 24 && sent_items < TOTAL_ITEMS)
                begin
                    burst = $urandom_range(1, window_in_use());
                    if (burst > TOTAL_ITEMS - sent_items)
                        burst = TOTAL_ITEMS - sent_items;
                    run_burst(burst, 1'b0);
                end
            end
            phase++;
        end

        settle();
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
